### rtl/spsb_pkg.sv
`default_nettype none
// ============================================================================
// spsb_pkg
// Shared types, constants and count conversion for the servo pulse
// schedule builder.
// ============================================================================
package spsb_pkg;

    localparam int unsigned NUM_LANES     = 6;
    localparam int unsigned CHANNELS_DEF  = 6;
    localparam int unsigned MAX_POS_DEF   = 180;
    localparam int unsigned QUEUE_DEPTH   = 2;

    localparam int unsigned POS_W  = 8;
    localparam int unsigned CNT_W  = 8;
    localparam int unsigned REG_W  = 8;
    localparam int unsigned IDX_W  = 1;

    localparam logic [IDX_W-1:0] REG_PULSE_MIN  = 1'd0;
    localparam logic [IDX_W-1:0] REG_PULSE_SPAN = 1'd1;

    localparam logic [REG_W-1:0] PULSE_MIN_RESET  = 8'd50;
    localparam logic [REG_W-1:0] PULSE_SPAN_RESET = 8'd200;

    // One decoded item: timer counts per lane and the lanes that are in use.
    typedef struct packed {
        logic [NUM_LANES-1:0][CNT_W-1:0] counts;
        logic [NUM_LANES-1:0]            present;
    } sched_job_t;

    // One schedule entry as it leaves the block.
    typedef struct packed {
        logic [CNT_W-1:0]     delay_counts;
        logic [NUM_LANES-1:0] channel_mask;
        logic                 last_entry;
    } sched_entry_t;

    // Pulse length in tens of microseconds to timer counts: len + len/4 - 1,
    // kept at zero for a zero length and saturated at the counter maximum.
    function automatic logic [CNT_W-1:0] len_to_counts(input logic [REG_W-1:0] len);
        logic [CNT_W:0] c;
        c = {1'b0, len} + {3'b000, len[REG_W-1:2]};
        if (c != '0)
        begin
            c = c - 1'b1;
        end
        if (c[CNT_W])
        begin
            return {CNT_W{1'b1}};
        end
        return c[CNT_W-1:0];
    endfunction

endpackage
`default_nettype wire

### rtl/spsb_queue.sv
`default_nettype none
// ============================================================================
// spsb_queue
// Small first-in first-out buffer of registers with full and empty flags.
// ============================================================================
module spsb_queue
    import spsb_pkg::*;
#(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = QUEUE_DEPTH
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] rdata,
    output logic                  empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W_Q = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W_Q-1:0] FULL_CNT = CNT_W_Q'(DEPTH);

    logic [WIDTH-1:0]   mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W_Q-1:0] fill_reg, fill_next;
    logic               do_push, do_pop;

    assign full    = (fill_reg == FULL_CNT);
    assign empty   = (fill_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule
`default_nettype wire

### rtl/spsb_front.sv
`default_nettype none
// ============================================================================
// spsb_front
// Two-stage scaling pipeline: position to pulse length to timer counts,
// one lane per channel.
// ============================================================================
module spsb_front
    import spsb_pkg::*;
#(
    parameter int unsigned CHANNELS = CHANNELS_DEF,
    parameter int unsigned MAX_POS  = MAX_POS_DEF
)
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 push,
    input  wire logic [NUM_LANES-1:0][POS_W-1:0]      position,
    input  wire logic [NUM_LANES-1:0]                 present_mask,
    output logic                                      full,
    input  wire logic [REG_W-1:0]                     pulse_span,
    output logic                                      job_valid,
    output sched_job_t                                job,
    input  wire logic                                 job_full
);

    localparam int unsigned PROD_W  = REG_W + POS_W;
    // Reciprocal of MAX_POS; exact floor division for any 16-bit product.
    localparam int unsigned SHIFT   = 24;
    localparam int unsigned RECIP_W = SHIFT + 1;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << SHIFT) + 64'(MAX_POS) - 64'd1) / 64'(MAX_POS));
    localparam logic [POS_W-1:0] MAX_POS_V = POS_W'(MAX_POS);
    localparam logic [NUM_LANES-1:0] CH_MASK = NUM_LANES'((1 << CHANNELS) - 1);

    logic [PROD_W-1:0]         prod_reg [CHANNELS];
    logic [PROD_W-1:0]         prod_next [CHANNELS];
    logic [NUM_LANES-1:0]      present_reg;
    logic                      v1_reg;
    logic                      v2_reg;
    sched_job_t                job_reg, job_next;
    logic                      s1_ready, s2_ready, accept;
    logic [PROD_W+RECIP_W-1:0] scaled [CHANNELS];
    logic [POS_W-1:0]          clamped [CHANNELS];

    assign s2_ready  = !v2_reg || !job_full;
    assign s1_ready  = !v1_reg || s2_ready;
    assign full      = !s1_ready;
    assign accept    = push && s1_ready;
    assign job_valid = v2_reg;
    assign job       = job_reg;

    always_comb
    begin
        for (int i = 0; i < CHANNELS; i++)
        begin
            clamped[i]   = (position[i] > MAX_POS_V) ? MAX_POS_V : position[i];
            prod_next[i] = PROD_W'(pulse_span * clamped[i]);
        end
    end

    always_comb
    begin
        job_next = '0;
        job_next.present = present_reg;
        for (int i = 0; i < CHANNELS; i++)
        begin
            scaled[i] = (PROD_W+RECIP_W)'(prod_reg[i] * RECIP);
            job_next.counts[i] = len_to_counts(scaled[i][SHIFT +: REG_W]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                v1_reg <= push;
            end
            if (s2_ready)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prod_reg    <= prod_next;
            present_reg <= present_mask & CH_MASK;
        end
        if (s2_ready && v1_reg)
        begin
            job_reg <= job_next;
        end
    end

endmodule
`default_nettype wire

### rtl/spsb_back.sv
`default_nettype none
// ============================================================================
// spsb_back
// Schedule emitter: walks the distinct channel counts in ascending order,
// one entry per cycle while entry_full is low.
// ============================================================================
module spsb_back
    import spsb_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             job_valid,
    input  wire sched_job_t       job,
    output logic                  job_pop,
    input  wire logic [REG_W-1:0] min_pulse,
    input  wire logic             entry_full,
    output logic                  entry_push,
    output sched_entry_t          entry
);

    logic                            busy_reg, busy_next;
    logic                            first_reg, first_next;
    logic [NUM_LANES-1:0][CNT_W-1:0] cnt_reg;
    logic [NUM_LANES-1:0]            present_reg;
    logic [NUM_LANES-1:0]            rem_reg, rem_next;
    logic [CNT_W-1:0]                prev_reg, prev_next;
    logic [CNT_W-1:0]                best;
    logic [NUM_LANES-1:0]            hit;
    logic [NUM_LANES-1:0]            rem_after;
    logic                            last;
    logic                            emit;
    logic [NUM_LANES-1:0]            nonzero;

    assign emit = busy_reg && !entry_full;

    // Smallest count among the channels not yet scheduled.
    always_comb
    begin
        best = {CNT_W{1'b1}};
        for (int i = 0; i < NUM_LANES; i++)
        begin
            if (rem_reg[i] && (cnt_reg[i] < best))
            begin
                best = cnt_reg[i];
            end
        end
        for (int i = 0; i < NUM_LANES; i++)
        begin
            hit[i] = rem_reg[i] && (cnt_reg[i] == best);
        end
    end

    // The first entry carries the minimum pulse and every channel whose
    // count is zero; later entries each close one distinct count.
    always_comb
    begin
        if (first_reg)
        begin
            entry.delay_counts = len_to_counts(min_pulse);
            entry.channel_mask = present_reg & ~rem_reg;
            rem_after          = rem_reg;
        end
        else
        begin
            entry.delay_counts = best - prev_reg;
            entry.channel_mask = hit;
            rem_after          = rem_reg & ~hit;
        end
        last             = (rem_after == '0);
        entry.last_entry = last;
    end

    assign entry_push = emit;
    assign job_pop    = job_valid && (!busy_reg || (emit && last));

    always_comb
    begin
        for (int i = 0; i < NUM_LANES; i++)
        begin
            nonzero[i] = (job.counts[i] != '0);
        end
    end

    always_comb
    begin
        busy_next  = busy_reg;
        first_next = first_reg;
        rem_next   = rem_reg;
        prev_next  = prev_reg;
        if (job_pop)
        begin
            busy_next  = 1'b1;
            first_next = 1'b1;
            rem_next   = job.present & nonzero;
            prev_next  = '0;
        end
        else if (emit)
        begin
            busy_next  = !last;
            first_next = 1'b0;
            rem_next   = rem_after;
            if (!first_reg)
            begin
                prev_next = best;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            first_reg <= 1'b0;
            rem_reg   <= '0;
            prev_reg  <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            first_reg <= first_next;
            rem_reg   <= rem_next;
            prev_reg  <= prev_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            cnt_reg     <= job.counts;
            present_reg <= job.present;
        end
    end

endmodule
`default_nettype wire

### rtl/servo_pulse_schedule_builder.sv
`default_nettype none
// ============================================================================
// servo_pulse_schedule_builder
// Turns six servo positions into a pulse-off schedule of timer count deltas
// and channel masks.
// ============================================================================
//
//  Channel   Handshake            Payload
//  -------   ------------------   ------------------------------------------
//  input     push / full          position_0..position_5, present_mask
//  result    empty / pop          delay_counts, channel_mask, last_entry
//  config    cfg_wr_en            cfg_index, cfg_wdata
//
//  An item enters the two-stage scaling pipeline in any cycle that full is
//  low; it then passes the scaling registers, the middle queue, the emitter
//  and the result queue before its first entry shows on the result ports.
//  The emitter produces one entry per cycle while the result queue is not
//  full; an item yields one entry plus one per distinct nonzero count: 1 to 7.
//  A two-entry queue sits between scaling and emitter and another one in
//  front of the result ports, so either side may stall on its own.
//  Reset clears all flags and loads the register defaults; no memory sweep.
//
module servo_pulse_schedule_builder
    import spsb_pkg::*;
#(
    parameter int unsigned CHANNELS = CHANNELS_DEF,
    parameter int unsigned MAX_POS  = MAX_POS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    output logic                      full,
    input  wire logic [POS_W-1:0]     position_0,
    input  wire logic [POS_W-1:0]     position_1,
    input  wire logic [POS_W-1:0]     position_2,
    input  wire logic [POS_W-1:0]     position_3,
    input  wire logic [POS_W-1:0]     position_4,
    input  wire logic [POS_W-1:0]     position_5,
    input  wire logic [NUM_LANES-1:0] present_mask,
    output logic                      empty,
    input  wire logic                 pop,
    output logic [CNT_W-1:0]          delay_counts,
    output logic [NUM_LANES-1:0]      channel_mask,
    output logic                      last_entry,
    input  wire logic                 cfg_wr_en,
    input  wire logic [IDX_W-1:0]     cfg_index,
    input  wire logic [REG_W-1:0]     cfg_wdata
);

    localparam int unsigned JOB_W   = $bits(sched_job_t);
    localparam int unsigned ENTRY_W = $bits(sched_entry_t);

    logic [REG_W-1:0] min_pulse_reg;
    logic [REG_W-1:0] pulse_span_reg;

    logic [NUM_LANES-1:0][POS_W-1:0] position;
    logic                            front_valid;
    sched_job_t                      front_job;
    logic                            mid_full, mid_empty, mid_pop;
    logic [JOB_W-1:0]                mid_rdata;
    sched_job_t                      back_job;
    logic                            entry_push, out_full;
    sched_entry_t                    entry;
    logic [ENTRY_W-1:0]              out_rdata;
    sched_entry_t                    head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_pulse_reg  <= PULSE_MIN_RESET;
            pulse_span_reg <= PULSE_SPAN_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_PULSE_MIN:  min_pulse_reg  <= cfg_wdata;
                REG_PULSE_SPAN: pulse_span_reg <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    assign position[0] = position_0;
    assign position[1] = position_1;
    assign position[2] = position_2;
    assign position[3] = position_3;
    assign position[4] = position_4;
    assign position[5] = position_5;

    spsb_front #(
        .CHANNELS (CHANNELS),
        .MAX_POS  (MAX_POS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .position     (position),
        .present_mask (present_mask),
        .full         (full),
        .pulse_span   (pulse_span_reg),
        .job_valid    (front_valid),
        .job          (front_job),
        .job_full     (mid_full)
    );

    spsb_queue #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_mid_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (front_valid),
        .wdata (JOB_W'(front_job)),
        .full  (mid_full),
        .pop   (mid_pop),
        .rdata (mid_rdata),
        .empty (mid_empty)
    );

    assign back_job = sched_job_t'(mid_rdata);

    spsb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (!mid_empty),
        .job        (back_job),
        .job_pop    (mid_pop),
        .min_pulse  (min_pulse_reg),
        .entry_full (out_full),
        .entry_push (entry_push),
        .entry      (entry)
    );

    spsb_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_out_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (entry_push),
        .wdata (ENTRY_W'(entry)),
        .full  (out_full),
        .pop   (pop),
        .rdata (out_rdata),
        .empty (empty)
    );

    assign head         = sched_entry_t'(out_rdata);
    assign delay_counts = head.delay_counts;
    assign channel_mask = head.channel_mask;
    assign last_entry   = head.last_entry;

endmodule
`default_nettype wire
